/* rtl/core/wtf8d_pkg.sv */
// Shared types, constants and the lead byte decode function for the
// WTF-8 stream decoder. No dependencies.
`timescale 1ns / 1ps

package wtf8d_pkg;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;

    localparam logic [7:0]  TRAIL_MASK   = 8'h3F;
    localparam logic [7:0]  TRAIL_TAG    = 8'h80;
    localparam logic [7:0]  TRAIL_SEL    = 8'hC0;
    localparam logic [20:0] MIN_TWO      = 21'h80;
    localparam logic [20:0] MIN_THREE    = 21'h800;
    localparam logic [20:0] MIN_FOUR     = 21'h10000;
    localparam logic [20:0] LIMIT_FIRST  = 21'h110;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  status;
        logic        run_end;
    } result_t;

    typedef struct packed {
        logic [20:0] acc;
        logic [1:0]  left;
        logic [1:0]  total;
        logic        bad;
        logic        disc;
    } state_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_out_t;

    typedef struct packed {
        logic        hit;
        logic        opens;
        result_t     res;
        logic [20:0] acc;
        logic [1:0]  total;
    } start_t;

    // Decode a byte that arrives outside any open sequence.
    function automatic start_t start_byte(input logic [7:0] b, input logic last);
        start_t s;
        s.hit            = 1'b1;
        s.opens          = 1'b0;
        s.res.code_point = '0;
        s.res.status     = STATUS_INVALID;
        s.res.run_end    = 1'b0;
        s.acc            = '0;
        s.total          = '0;
        if (b < 8'h80)
        begin
            s.res.code_point = {13'd0, b};
            s.res.status     = STATUS_OK;
        end
        else if (b >= 8'hC0 && b < 8'hF8)
        begin
            s.opens      = 1'b1;
            s.hit        = last;
            s.res.status = STATUS_TRUNC;
            if (b < 8'hE0)
            begin
                s.acc   = {16'd0, b[4:0]};
                s.total = 2'd1;
            end
            else if (b < 8'hF0)
            begin
                s.acc   = {17'd0, b[3:0]};
                s.total = 2'd2;
            end
            else
            begin
                s.acc   = {18'd0, b[2:0]};
                s.total = 2'd3;
            end
        end
        return s;
    endfunction

endpackage

/* rtl/core/wtf8d_step.sv */
// Combinational byte step: next decoder state and up to two results.
// Depends on wtf8d_pkg.
`timescale 1ns / 1ps

module wtf8d_step (
    input  wtf8d_pkg::state_t    cur,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output wtf8d_pkg::state_t    nxt,
    output wtf8d_pkg::step_out_t out
);
    import wtf8d_pkg::*;

    logic        is_trail;
    logic [20:0] acc_sh;
    logic        bad_n;
    logic [1:0]  left_n;
    logic [20:0] min_v;
    start_t      sb;

    assign is_trail = (data_byte & TRAIL_SEL) == TRAIL_TAG;
    assign acc_sh   = {cur.acc[14:0], data_byte[5:0] & TRAIL_MASK[5:0]};
    assign bad_n    = cur.bad | ((cur.total == 2'd3) && (cur.left == 2'd3)
                                 && (acc_sh >= LIMIT_FIRST));
    assign left_n   = cur.left - 2'd1;
    assign min_v    = (cur.total == 2'd3) ? MIN_FOUR :
                      (cur.total == 2'd2) ? MIN_THREE : MIN_TWO;
    assign sb       = start_byte(data_byte, last_byte);

    always_comb
    begin
        result_t r_inv;
        r_inv.code_point = '0;
        r_inv.status     = STATUS_INVALID;
        r_inv.run_end    = 1'b0;
        nxt       = cur;
        out.count = 2'd0;
        out.res0  = r_inv;
        out.res1  = r_inv;
        if (cur.left != 2'd0)
        begin
            if (is_trail)
            begin
                nxt.acc  = acc_sh;
                nxt.bad  = bad_n;
                nxt.left = left_n;
                if (left_n == 2'd0)
                begin
                    out.count = 2'd1;
                    if (bad_n || acc_sh < min_v)
                    begin
                        nxt.disc = 1'b1;
                    end
                    else
                    begin
                        out.res0.code_point = acc_sh;
                        out.res0.status     = STATUS_OK;
                        nxt.disc            = 1'b0;
                    end
                    nxt.acc   = '0;
                    nxt.total = '0;
                    nxt.bad   = 1'b0;
                end
                else if (last_byte)
                begin
                    out.count        = 2'd1;
                    out.res0.status  = STATUS_TRUNC;
                end
            end
            else
            begin
                // The open sequence is broken; the interrupting byte starts fresh.
                out.count = 2'd1;
                nxt       = '0;
                if (sb.opens)
                begin
                    nxt.acc   = sb.acc;
                    nxt.total = sb.total;
                    nxt.left  = sb.total;
                end
                if (sb.hit)
                begin
                    out.res1  = sb.res;
                    out.count = 2'd2;
                end
            end
        end
        else if (!(cur.disc && is_trail))
        begin
            nxt.disc = 1'b0;
            nxt.bad  = 1'b0;
            if (sb.opens)
            begin
                nxt.acc   = sb.acc;
                nxt.total = sb.total;
                nxt.left  = sb.total;
            end
            if (sb.hit)
            begin
                out.res0  = sb.res;
                out.count = 2'd1;
            end
        end
        if (out.count == 2'd1)
            out.res0.run_end = 1'b1;
        if (out.count == 2'd2)
            out.res1.run_end = 1'b1;
        if (last_byte)
            nxt = '0;
    end

endmodule

/* rtl/core/wtf8d_fifo.sv */
// Small result queue that takes up to two results per cycle and delivers one.
// Depends on wtf8d_pkg.
`timescale 1ns / 1ps

module wtf8d_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  wtf8d_pkg::step_out_t      wdata,
    input  logic                      pop,
    output logic [wtf8d_pkg::CNT_W-1:0] count,
    output wtf8d_pkg::result_t        head
);
    import wtf8d_pkg::*;

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         n_push;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign n_push       = push ? wdata.count : 2'd0;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign count_next   = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    assign count        = count_reg;
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem_reg[wr_ptr_reg] <= wdata.res0;
        if (n_push == 2'd2)
            mem_reg[wr_ptr_plus1] <= wdata.res1;
    end

endmodule

/* rtl/core/wtf8_stream_decoder.sv */
// Top level of the WTF-8 stream decoder: input register, byte step logic,
// result queue. Depends on wtf8d_pkg, wtf8d_step and wtf8d_fifo.
`timescale 1ns / 1ps
// A byte accepted into the input register is decoded, and its results are written
// into the result queue, once the queue has room for two results.
// Throughput: one byte per cycle; a byte that yields two results takes two
// output transactions, and a byte waiting in the input register stalls the
// input while the four-entry result queue holds more than two results.
// Reset (rst_n low, asynchronous) clears the decoder state and empties the queue.

module wtf8_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic [1:0]  status,
    output logic        run_end
);
    import wtf8d_pkg::*;

    // Input register holding one byte transaction ahead of the decode step.
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Decoder state carried between bytes.
    state_t     state_reg, state_next;

    step_out_t  step_res;
    logic [CNT_W-1:0] q_count;
    result_t    q_head;
    logic       advance;
    logic       load;
    logic       pop;

    // The held byte moves on only when the queue has room for two results,
    // which covers the worst case of an interrupted sequence.
    assign advance  = in_valid_reg && (q_count <= CNT_W'(FIFO_DEPTH - 2));
    assign in_stall = in_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (load)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    wtf8d_step u_step (
        .cur       (state_reg),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .nxt       (state_next),
        .out       (step_res)
    );

    // Results leave the queue one transaction at a time.
    assign out_valid = (q_count != '0);
    assign pop       = out_valid && !out_stall;

    wtf8d_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (advance),
        .wdata (step_res),
        .pop   (pop),
        .count (q_count),
        .head  (q_head)
    );

    assign code_point = q_head.code_point;
    assign status     = q_head.status;
    assign run_end    = q_head.run_end;

endmodule

/* rtl/core/wtf8d_checker.sv */
// Port-level checks for the WTF-8 stream decoder, bound to the top level.
// Depends on wtf8d_pkg and wtf8_stream_decoder.
`timescale 1ns / 1ps

module wtf8d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  data_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [20:0] code_point,
    input logic [1:0]  status,
    input logic        run_end
);
    import wtf8d_pkg::*;

    // A stalled input byte stays on the port unchanged until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(last_byte))
        else $error("stalled input byte changed");

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_point)
                                   && $stable(status) && $stable(run_end))
        else $error("stalled result changed");

    // Error results carry a zero code point.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> code_point == 21'd0)
        else $error("error result with nonzero code point");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_INVALID
                      || status == STATUS_TRUNC)
        else $error("undefined status code");

    // Good results stay within the Unicode range.
    a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK |-> code_point <= 21'h10FFFF)
        else $error("code point out of range");

endmodule

bind wtf8_stream_decoder wtf8d_checker u_wtf8d_checker (.*);
